[hdl/spp_pkg.sv]
// Package for the step sequencer playhead: request payload types,
// register index codes and a narrow modulo helper. No dependencies.
package spp_pkg;

    typedef struct packed {
        logic [7:0] tick_in_step;
        logic       loop_start;
        logic       sixteenth_tick;
    } spp_in_t;

    typedef struct packed {
        logic        address_valid;
        logic [3:0]  step_now;
        logic [2:0]  pattern_now;
        logic [11:0] event_address;
    } spp_out_t;

    localparam int NUM_STEPS = 16;

    localparam logic [2:0] REG_STEP_STRIDE   = 3'd0;
    localparam logic [2:0] REG_FOLD_ENABLE   = 3'd1;
    localparam logic [2:0] REG_WINDOW_SHIFT  = 3'd2;
    localparam logic [2:0] REG_WINDOW_LENGTH = 3'd3;
    localparam logic [2:0] REG_PATTERN_COUNT = 3'd4;
    localparam logic [2:0] REG_CHAIN_ENABLE  = 3'd5;
    localparam logic [2:0] REG_LOOPS_EACH    = 3'd6;
    localparam logic [2:0] REG_RUN_ENABLE    = 3'd7;

    // 4-bit remainder by restoring subtraction, one quotient bit per step
    function automatic logic [3:0] mod4(input logic [3:0] num, input logic [3:0] den);
        logic [7:0] rem;
        logic [7:0] sub;
        rem = {4'd0, num};
        for (int i = 3; i >= 0; i--) begin
            sub = {4'd0, den} << i;
            if (den != 4'd0 && rem >= sub) begin
                rem = rem - sub;
            end
        end
        return rem[3:0];
    endfunction

endpackage

[hdl/step_sequencer_playhead_unit.sv]
// Step sequencer playhead: cursor, window and pattern chaining per timing tick.
// Request held in the input reg, then result in the result reg; the state update is
// one compare-and-add pass. Throughput: one request per cycle unless m_ready stalls.
// s_ready follows m_ready through the result register; cfg_ready is always high.
// Reset (aresetn low, synchronous): all playhead state zero, registers to defaults,
// both pipeline stages empty.
module step_sequencer_playhead_unit
    import spp_pkg::*;
#(
    parameter int TICKS_PER_STEP = 240,
    parameter int MAX_PATTERNS   = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  spp_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output spp_out_t   m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int PAT_MAX = (MAX_PATTERNS < 15) ? MAX_PATTERNS : 15;
    localparam int PAT_W   = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int ADDR_NW = $clog2(NUM_STEPS * TICKS_PER_STEP);
    localparam int SUM_W   = (ADDR_NW > 12) ? ADDR_NW : 12;
    localparam int REM_W   = 19;

    // configuration registers
    logic [3:0] step_stride_reg;
    logic       fold_enable_reg;
    logic [4:0] window_shift_reg;
    logic [4:0] window_length_reg;
    logic [3:0] pattern_count_reg;
    logic       chain_enable_reg;
    logic [7:0] loops_each_reg;
    logic       run_enable_reg;

    // playhead state
    logic [3:0]       cursor_reg, cursor_next;
    logic             moving_back_reg, moving_back_next;
    logic [3:0]       window_start_reg, window_start_next;
    logic [4:0]       steps_done_reg, steps_done_next;
    logic [PAT_W-1:0] pattern_sel_reg, pattern_sel_next;
    logic [7:0]       loops_left_reg, loops_left_next;
    logic             has_started_reg, has_started_next;

    // pipeline
    logic     in_valid_reg;
    spp_in_t  in_data_reg;
    logic     out_valid_reg;
    spp_out_t out_data_reg, out_data_next;
    logic     advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_stride_reg   <= 4'd1;
            fold_enable_reg   <= 1'b0;
            window_shift_reg  <= 5'd0;
            window_length_reg <= 5'd16;
            pattern_count_reg <= 4'd1;
            chain_enable_reg  <= 1'b0;
            loops_each_reg    <= 8'd1;
            run_enable_reg    <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_STEP_STRIDE:   step_stride_reg   <= cfg_data[3:0];
                REG_FOLD_ENABLE:   fold_enable_reg   <= cfg_data[0];
                REG_WINDOW_SHIFT:  window_shift_reg  <= cfg_data[4:0];
                REG_WINDOW_LENGTH: window_length_reg <= cfg_data[4:0];
                REG_PATTERN_COUNT: pattern_count_reg <= cfg_data[3:0];
                REG_CHAIN_ENABLE:  chain_enable_reg  <= cfg_data[0];
                REG_LOOPS_EACH:    loops_each_reg    <= cfg_data;
                REG_RUN_ENABLE:    run_enable_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // state update for the request in the input register
    logic [4:0]        eff_len;
    logic [3:0]        pat_cnt;
    logic              loop_go;
    logic              step_go;
    logic signed [7:0] c_val, start_s, end_s, over_s, stride_s;
    logic              back_tmp;
    logic [4:0]        done_inc;

    always_comb begin
        if (window_length_reg == 5'd0) begin
            eff_len = 5'd1;
        end else if (window_length_reg > 5'd16) begin
            eff_len = 5'd16;
        end else begin
            eff_len = window_length_reg;
        end
        if ({3'd0, pattern_count_reg} > 7'(PAT_MAX)) begin
            pat_cnt = 4'(PAT_MAX);
        end else begin
            pat_cnt = pattern_count_reg;
        end

        loop_go          = run_enable_reg && in_data_reg.loop_start;
        has_started_next = has_started_reg || loop_go;
        pattern_sel_next = pattern_sel_reg;
        loops_left_next  = loops_left_reg;
        if (loop_go && chain_enable_reg && pat_cnt > 4'd1) begin
            if (loops_left_reg <= 8'd1) begin
                pattern_sel_next = PAT_W'(mod4(4'(pattern_sel_reg) + 4'd1, pat_cnt));
                loops_left_next  = loops_each_reg;
            end else begin
                loops_left_next = loops_left_reg - 8'd1;
            end
        end

        step_go  = run_enable_reg && has_started_next && in_data_reg.sixteenth_tick;
        stride_s = $signed({4'd0, step_stride_reg});
        start_s  = $signed({4'd0, window_start_reg});
        end_s    = start_s + $signed({3'd0, eff_len});
        c_val    = moving_back_reg ? $signed({4'd0, cursor_reg}) - stride_s
                                   : $signed({4'd0, cursor_reg}) + stride_s;
        back_tmp = moving_back_reg;
        over_s   = 8'sd0;
        if (c_val < start_s) begin
            over_s = start_s - c_val;
            if (fold_enable_reg) begin
                c_val    = start_s + over_s;
                back_tmp = 1'b0;
            end else begin
                c_val = end_s - over_s - 8'sd1;
            end
        end else if (c_val >= 8'sd16 || c_val >= end_s) begin
            over_s = (c_val >= 8'sd16) ? c_val - 8'sd16 : c_val - end_s;
            if (fold_enable_reg) begin
                c_val    = end_s - over_s - 8'sd1;
                back_tmp = 1'b1;
            end else begin
                c_val = start_s + over_s;
            end
        end

        done_inc          = steps_done_reg + 5'd1;
        cursor_next       = cursor_reg;
        moving_back_next  = moving_back_reg;
        steps_done_next   = steps_done_reg;
        window_start_next = window_start_reg;
        if (step_go) begin
            cursor_next      = c_val[3:0];
            moving_back_next = back_tmp;
            if (done_inc >= eff_len) begin
                steps_done_next = 5'd0;
                // rotation modulo 16 only needs the low four bits of the shift
                window_start_next = window_start_reg + window_shift_reg[3:0];
            end else begin
                steps_done_next = done_inc;
            end
        end
    end

    // result: tick position reduced modulo TICKS_PER_STEP by constant subtractions
    logic [REM_W-1:0]  tick_rem;
    logic [SUM_W-1:0]  addr_sum;
    logic [PAT_W+2:0]  pat_ext;
    logic              valid_now;

    always_comb begin
        tick_rem = REM_W'(in_data_reg.tick_in_step);
        for (int i = 7; i >= 0; i--) begin
            if (tick_rem >= (REM_W'(TICKS_PER_STEP) << i)) begin
                tick_rem = tick_rem - (REM_W'(TICKS_PER_STEP) << i);
            end
        end
        // cursor*T + rem stays below 16*T, so no wrap is needed
        addr_sum  = SUM_W'(cursor_next) * SUM_W'(TICKS_PER_STEP) + SUM_W'(tick_rem);
        pat_ext   = {3'd0, pattern_sel_next};
        valid_now = run_enable_reg && has_started_next;

        out_data_next.address_valid = valid_now;
        out_data_next.step_now      = cursor_next;
        out_data_next.pattern_now   = pat_ext[2:0];
        out_data_next.event_address = valid_now ? addr_sum[11:0] : 12'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            cursor_reg       <= 4'd0;
            moving_back_reg  <= 1'b0;
            window_start_reg <= 4'd0;
            steps_done_reg   <= 5'd0;
            pattern_sel_reg  <= '0;
            loops_left_reg   <= 8'd0;
            has_started_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg    <= 1'b1;
                cursor_reg       <= cursor_next;
                moving_back_reg  <= moving_back_next;
                window_start_reg <= window_start_next;
                steps_done_reg   <= steps_done_next;
                pattern_sel_reg  <= pattern_sel_next;
                loops_left_reg   <= loops_left_next;
                has_started_reg  <= has_started_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_addr_zero_when_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.address_valid) |-> (m_data.event_address == 12'd0))
        else $error("event address nonzero without a valid address");

    a_steps_done_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        steps_done_reg < 5'd16)
        else $error("window step count out of range");

    a_pattern_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {{(8-PAT_W){1'b0}}, pattern_sel_reg} < 8'(PAT_MAX > 1 ? PAT_MAX : 2))
        else $error("pattern index beyond pattern limit");

    a_frozen_when_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !run_enable_reg) |=> ($stable(cursor_reg) && $stable(pattern_sel_reg)))
        else $error("playhead moved while stopped");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");
`endif

endmodule

[bench/step_sequencer_playhead_unit_tb.sv]
// Self-checking bench for step_sequencer_playhead_unit: a directed table, then
// random tick streams, each result compared against a table value or a playhead model.
// Depends on spp_pkg and the unit under test only.
`timescale 1ns / 100ps

module step_sequencer_playhead_unit_tb;
    import spp_pkg::*;

    localparam int TICKS_PER_STEP = 240;
    localparam int DRAIN_PAUSE    = 4;
    localparam int RANDOM_ITEMS   = 1950;

    typedef struct {
        bit         is_cfg;
        logic [2:0] idx;
        logic [7:0] val;
        spp_in_t    d;
        bit         typed;
        spp_out_t   want;
    } dir_row_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    spp_in_t    s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    spp_out_t   m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    // playhead register copies, at reset defaults
    logic [3:0] cf_stride = 4'd1;
    logic       cf_fold   = 1'b0;
    logic [4:0] cf_shift  = 5'd0;
    logic [4:0] cf_len    = 5'd16;
    logic [3:0] cf_pcount = 4'd1;
    logic       cf_chain  = 1'b0;
    logic [7:0] cf_loops  = 8'd1;
    logic       cf_run    = 1'b0;

    // playhead state copies
    logic [3:0] pos          = '0;
    logic       heading_back = 1'b0;
    logic [3:0] win_base     = '0;
    logic [4:0] win_count    = '0;
    logic [2:0] pat          = '0;
    logic [8:0] loops_rem    = '0;
    logic       started      = 1'b0;

    spp_out_t expected_heads[$];
    int       mismatch_count = 0;
    bit       no_idle        = 1'b0;

    step_sequencer_playhead_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic spp_out_t playhead_predict(input spp_in_t d);
        spp_out_t r;
        int       cnt;
        int       span;
        int       lo;
        int       hi;
        int       c;
        int       over;
        int       sh;
        if (cf_run) begin
            if (d.loop_start) begin
                cnt = (cf_pcount > 4'd8) ? 8 : int'(cf_pcount);
                started = 1'b1;
                if (cf_chain && cnt > 1) begin
                    // last loop of this pattern: move on and reload the count
                    if (loops_rem <= 9'd1) begin
                        pat = 3'((int'(pat) + 1) % cnt);
                        loops_rem = {1'b0, cf_loops};
                    end else begin
                        loops_rem = loops_rem - 9'd1;
                    end
                end
            end
            if (started && d.sixteenth_tick) begin
                span = int'(cf_len);
                if (span < 1) span = 1;
                if (span > NUM_STEPS) span = NUM_STEPS;
                lo = int'(win_base);
                hi = lo + span;
                c  = heading_back ? int'(pos) - int'(cf_stride) : int'(pos) + int'(cf_stride);
                if (c < lo || c < 0) begin
                    over = lo - c;
                    if (cf_fold) begin
                        c = lo + over;
                        heading_back = 1'b0;
                    end else begin
                        c = hi - over - 1;
                    end
                end else if (c >= NUM_STEPS || c >= hi) begin
                    over = (c >= NUM_STEPS) ? c - NUM_STEPS : c - hi;
                    if (cf_fold) begin
                        c = hi - over - 1;
                        heading_back = 1'b1;
                    end else begin
                        c = lo + over;
                    end
                end
                pos = 4'(c);
                win_count = win_count + 5'd1;
                // rotate the window once a full pass of it has played
                if (int'(win_count) >= span) begin
                    sh = $signed(cf_shift);
                    win_count = '0;
                    win_base = 4'(lo + sh);
                end
            end
        end
        r.address_valid = cf_run && started;
        r.step_now      = pos;
        r.pattern_now   = pat;
        r.event_address = r.address_valid
            ? 12'((int'(pos) * TICKS_PER_STEP + int'(d.tick_in_step) % TICKS_PER_STEP)
                  % (NUM_STEPS * TICKS_PER_STEP))
            : 12'd0;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [2:0] idx, input logic [7:0] val);
        dir_row_t r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic dir_row_t tick_row(input logic [7:0] tick, input logic ls,
                                          input logic sx, input bit typed,
                                          input spp_out_t want);
        dir_row_t r;
        r       = '{default: '0};
        r.d     = '{tick_in_step: tick, loop_start: ls, sixteenth_tick: sx};
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_item(input spp_in_t d, input bit typed, input spp_out_t want);
        spp_out_t calc;
        while (!no_idle && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        calc = playhead_predict(d);
        expected_heads.push_back(typed ? want : calc);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_heads.size() != 0) @(negedge aclk);
        repeat (DRAIN_PAUSE) @(negedge aclk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write of a batch
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_STEP_STRIDE:   cf_stride = val[3:0];
            REG_FOLD_ENABLE:   cf_fold   = val[0];
            REG_WINDOW_SHIFT:  cf_shift  = val[4:0];
            REG_WINDOW_LENGTH: cf_len    = val[4:0];
            REG_PATTERN_COUNT: cf_pcount = val[3:0];
            REG_CHAIN_ENABLE:  cf_chain  = val[0];
            REG_LOOPS_EACH:    cf_loops  = val;
            REG_RUN_ENABLE:    cf_run    = val[0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // result side: check at the rising edge, move ready at the falling edge
    initial begin
        spp_out_t want;
        int       hold_left;
        bit       held;
        int       seen;
        hold_left = 0;
        held      = 1'b0;
        seen      = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                seen++;
                if (expected_heads.size() == 0) begin
                    $error("result with no request pending: %h", m_data);
                    mismatch_count++;
                end else begin
                    want = expected_heads.pop_front();
                    if (m_data.address_valid !== want.address_valid) begin
                        $error("address_valid: expected %0d, got %0d",
                               want.address_valid, m_data.address_valid);
                        mismatch_count++;
                    end
                    if (m_data.step_now !== want.step_now) begin
                        $error("step_now: expected %0d, got %0d", want.step_now, m_data.step_now);
                        mismatch_count++;
                    end
                    if (m_data.pattern_now !== want.pattern_now) begin
                        $error("pattern_now: expected %0d, got %0d",
                               want.pattern_now, m_data.pattern_now);
                        mismatch_count++;
                    end
                    if (m_data.event_address !== want.event_address) begin
                        $error("event_address: expected %0d, got %0d",
                               want.event_address, m_data.event_address);
                        mismatch_count++;
                    end
                end
            end
            @(negedge aclk);
            // hold off once for a long stretch while requests keep coming
            if (!held && seen >= 400 && s_valid) begin
                held      = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= 14);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL step_sequencer_playhead_unit");
        $finish;
    end

    initial begin
        dir_row_t   rows[$];
        spp_in_t    d;
        logic [2:0] ri;
        logic [7:0] v;
        bit         in_cfg;
        int         random_items;
        int         phase_len;
        int         tick_pos;
        int         six_in_loop;
        int         loop_span;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // stopped after reset, then first start from step zero
        rows.push_back(tick_row(8'd0,   1'b1, 1'b1, 1'b1, '0));
        rows.push_back(tick_row(8'd255, 1'b1, 1'b0, 1'b1, '0));
        rows.push_back(cfg_row(REG_RUN_ENABLE, 8'd1));
        rows.push_back(tick_row(8'd239, 1'b0, 1'b1, 1'b1, '0));
        rows.push_back(tick_row(8'd0,   1'b1, 1'b1, 1'b1, {1'b1, 4'd1, 3'd0, 12'd240}));
        rows.push_back(tick_row(8'd255, 1'b0, 1'b0, 1'b1, {1'b1, 4'd1, 3'd0, 12'd255}));
        rows.push_back(tick_row(8'd239, 1'b0, 1'b1, 1'b1, {1'b1, 4'd2, 3'd0, 12'd719}));
        // widest stride with folding
        rows.push_back(cfg_row(REG_STEP_STRIDE, 8'd15));
        rows.push_back(cfg_row(REG_FOLD_ENABLE, 8'd1));
        rows.push_back(tick_row(8'd10, 1'b0, 1'b1, 1'b0, '0));
        rows.push_back(tick_row(8'd20, 1'b0, 1'b1, 1'b0, '0));
        rows.push_back(tick_row(8'd30, 1'b0, 1'b1, 1'b0, '0));
        // zero length window acts as one step; shift by -15
        rows.push_back(cfg_row(REG_WINDOW_LENGTH, 8'd0));
        rows.push_back(cfg_row(REG_WINDOW_SHIFT, 8'h11));
        rows.push_back(tick_row(8'd0,   1'b0, 1'b1, 1'b0, '0));
        rows.push_back(tick_row(8'd120, 1'b0, 1'b1, 1'b0, '0));
        // oversized window, stride zero, wrap
        rows.push_back(cfg_row(REG_WINDOW_LENGTH, 8'd31));
        rows.push_back(cfg_row(REG_WINDOW_SHIFT, 8'd15));
        rows.push_back(cfg_row(REG_FOLD_ENABLE, 8'd0));
        rows.push_back(cfg_row(REG_STEP_STRIDE, 8'd0));
        rows.push_back(tick_row(8'd200, 1'b0, 1'b1, 1'b0, '0));
        rows.push_back(tick_row(8'd240, 1'b0, 1'b1, 1'b0, '0));
        // chaining with an oversized pattern count and zero loops
        rows.push_back(cfg_row(REG_PATTERN_COUNT, 8'd15));
        rows.push_back(cfg_row(REG_CHAIN_ENABLE, 8'd1));
        rows.push_back(cfg_row(REG_LOOPS_EACH, 8'd0));
        rows.push_back(cfg_row(REG_STEP_STRIDE, 8'd7));
        rows.push_back(tick_row(8'd5, 1'b1, 1'b0, 1'b0, '0));
        rows.push_back(tick_row(8'd6, 1'b1, 1'b1, 1'b0, '0));
        rows.push_back(tick_row(8'd7, 1'b1, 1'b0, 1'b0, '0));
        // shrink the count so the pattern index sits beyond it
        rows.push_back(cfg_row(REG_PATTERN_COUNT, 8'd3));
        rows.push_back(cfg_row(REG_LOOPS_EACH, 8'd2));
        rows.push_back(tick_row(8'd50, 1'b1, 1'b0, 1'b0, '0));
        rows.push_back(tick_row(8'd60, 1'b1, 1'b1, 1'b0, '0));
        rows.push_back(tick_row(8'd70, 1'b1, 1'b0, 1'b0, '0));
        rows.push_back(tick_row(8'd80, 1'b1, 1'b1, 1'b0, '0));
        rows.push_back(cfg_row(REG_PATTERN_COUNT, 8'd8));
        rows.push_back(cfg_row(REG_LOOPS_EACH, 8'd255));
        rows.push_back(cfg_row(REG_WINDOW_SHIFT, 8'h10));
        rows.push_back(tick_row(8'd100, 1'b1, 1'b1, 1'b0, '0));
        rows.push_back(tick_row(8'd128, 1'b0, 1'b1, 1'b0, '0));
        // stopped: state frozen, no address
        rows.push_back(cfg_row(REG_RUN_ENABLE, 8'd0));
        rows.push_back(tick_row(8'd64,  1'b1, 1'b1, 1'b0, '0));
        rows.push_back(tick_row(8'd255, 1'b0, 1'b1, 1'b0, '0));

        in_cfg = 1'b0;
        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                if (!in_cfg) drain();
                in_cfg = 1'b1;
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                if (in_cfg) cfg_valid <= 1'b0;
                in_cfg = 1'b0;
                send_item(rows[i].d, rows[i].typed, rows[i].want);
            end
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            drain();
            for (int k = 0; k < 8; k++) begin
                ri = 3'(k);
                if ($urandom_range(1) == 1) begin
                    case (ri)
                        REG_STEP_STRIDE:   v = 8'($urandom_range(0, 15));
                        REG_FOLD_ENABLE:   v = 8'($urandom_range(0, 1));
                        REG_WINDOW_SHIFT:  v = 8'($urandom_range(0, 31));
                        REG_WINDOW_LENGTH: v = ($urandom_range(4) == 0)
                                               ? 8'($urandom_range(0, 31))
                                               : 8'($urandom_range(1, 16));
                        REG_PATTERN_COUNT: v = ($urandom_range(4) == 0)
                                               ? 8'($urandom_range(0, 15))
                                               : 8'($urandom_range(1, 8));
                        REG_CHAIN_ENABLE:  v = ($urandom_range(9) < 7) ? 8'd1 : 8'd0;
                        REG_LOOPS_EACH:    v = ($urandom_range(4) == 0)
                                               ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 4));
                        default:           v = ($urandom_range(9) != 0) ? 8'd1 : 8'd0;
                    endcase
                    write_reg(ri, v);
                end
            end
            cfg_valid <= 1'b0;

            tick_pos    = 0;
            six_in_loop = 0;
            loop_span   = $urandom_range(1, 8);
            phase_len   = $urandom_range(20, 80);
            repeat (phase_len) begin
                if ($urandom_range(9) < 3) begin
                    d.tick_in_step   = 8'($urandom_range(0, 255));
                    d.loop_start     = 1'($urandom_range(0, 1));
                    d.sixteenth_tick = 1'($urandom_range(0, 1));
                end else begin
                    // well-formed stream: advance the tick, flag sixteenth and loop edges
                    tick_pos += $urandom_range(20, 120);
                    d.loop_start     = 1'b0;
                    d.sixteenth_tick = 1'b0;
                    if (tick_pos >= TICKS_PER_STEP) begin
                        tick_pos         = 0;
                        d.sixteenth_tick = 1'b1;
                        six_in_loop++;
                        if (six_in_loop >= loop_span) begin
                            six_in_loop  = 0;
                            d.loop_start = 1'b1;
                        end
                    end
                    d.tick_in_step = 8'(tick_pos);
                end
                no_idle = (random_items >= 900 && random_items < 1200);
                send_item(d, 1'b0, '0);
                random_items++;
            end
        end

        no_idle = 1'b0;
        drain();
        repeat (6) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS step_sequencer_playhead_unit");
        end else begin
            $display("FAIL step_sequencer_playhead_unit");
        end
        $finish;
    end

endmodule
